[hdl/deq_pkg.sv]
// ============================================================================
// Double-ended queue package
// Shared codes for the double-ended queue: request kinds, result status
// codes and the states of the sequencer.
// ============================================================================
package deq_pkg;

  // Width of the reported entry count.
  localparam int unsigned CountOutW = 11;

  // Width of one stored word.
  localparam int unsigned WordW = 32;

  // Request kinds. Codes above the query code act as a query.
  typedef enum logic [2:0] {
    KIND_PUSH_FRONT = 3'd0,
    KIND_PUSH_BACK  = 3'd1,
    KIND_POP_FRONT  = 3'd2,
    KIND_POP_BACK   = 3'd3,
    KIND_QUERY      = 3'd4
  } deq_kind_e;

  // Result status codes.
  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_EMPTY = 2'd1,
    STATUS_FULL  = 2'd2
  } deq_status_e;

  // Sequencer states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_FILL,
    ST_OUT
  } deq_state_e;

endpackage

[hdl/deq_ram.sv]
// ============================================================================
// Double-ended queue entry memory
// Single write port, single read port synchronous RAM with registered read
// data. Contents are not reset.
// ============================================================================
module deq_ram #(
  parameter int unsigned Depth = 1024,
  parameter int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic                           clk_i,
  input  logic                           we_i,
  input  logic [AddrW-1:0]               waddr_i,
  input  logic [deq_pkg::WordW-1:0]      wdata_i,
  input  logic                           re_i,
  input  logic [AddrW-1:0]               raddr_i,
  output logic [deq_pkg::WordW-1:0]      rdata_o
);

  logic [deq_pkg::WordW-1:0] mem [Depth];
  logic [deq_pkg::WordW-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[hdl/double_ended_queue_unit.sv]
// ============================================================================
// Double-ended queue unit
// Ring-buffer deque of signed 32-bit words with push and pop at both ends.
// Front and back words are cached in registers; the entry memory refills
// the cache after a pop.
// ============================================================================
// Sequence: an accepted request passes through the execute state, then the
// fill state for a pop that leaves entries behind (one memory read refills
// the cache), then the output state, which waits until the output register is
// free. A new request is accepted only when the sequencer is back in idle.
// Reset: pointer, count, sequencer and output valid are cleared; the entry
// memory is not cleared and takes no clearing pass.
module double_ended_queue_unit #(
  parameter int unsigned DEPTH = 1024
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic [2:0]                           kind_i,
  input  logic signed [deq_pkg::WordW-1:0]     value_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic [1:0]                           status_o,
  output logic signed [deq_pkg::WordW-1:0]     popped_value_o,
  output logic [deq_pkg::CountOutW-1:0]        count_o,
  output logic                                 is_empty_o,
  output logic signed [deq_pkg::WordW-1:0]     front_value_o,
  output logic signed [deq_pkg::WordW-1:0]     back_value_o
);

  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam int unsigned SW   = CntW + 1;
  localparam logic [SW-1:0]   DepthS = SW'(DEPTH);
  localparam logic [CntW-1:0] DepthC = CntW'(DEPTH);
  localparam logic [AW-1:0]   LastA  = AW'(DEPTH - 1);

  // Reduce a sum below twice the depth to a ring index.
  function automatic logic [AW-1:0] wrap(input logic [SW-1:0] s);
    logic [SW-1:0] r;
    r = (s >= DepthS) ? (s - DepthS) : s;
    return AW'(r);
  endfunction

  deq_pkg::deq_state_e state_q, state_d;

  logic [2:0]                kind_q;
  logic [deq_pkg::WordW-1:0] value_q;
  logic [AW-1:0]             fp_q, fp_d;
  logic [CntW-1:0]           count_q, count_d;
  logic [deq_pkg::WordW-1:0] front_q, front_d;
  logic [deq_pkg::WordW-1:0] back_q, back_d;
  logic [1:0]                status_q, status_d;
  logic [deq_pkg::WordW-1:0] popped_q, popped_d;

  logic                      out_valid_q;
  logic [1:0]                out_status_q;
  logic [deq_pkg::WordW-1:0] out_popped_q;
  logic [deq_pkg::CountOutW-1:0] out_count_q;
  logic                      out_empty_q;
  logic [deq_pkg::WordW-1:0] out_front_q;
  logic [deq_pkg::WordW-1:0] out_back_q;

  logic                      mem_we, mem_re;
  logic [AW-1:0]             mem_waddr, mem_raddr;
  logic [deq_pkg::WordW-1:0] mem_rdata;
  logic                      need_read;
  logic                      out_load;

  logic                      is_push, is_pop, take_front;
  logic [AW-1:0]             fp_dec, fp_inc;

  assign is_push    = (kind_q == deq_pkg::KIND_PUSH_FRONT) ||
                      (kind_q == deq_pkg::KIND_PUSH_BACK);
  assign is_pop     = (kind_q == deq_pkg::KIND_POP_FRONT) ||
                      (kind_q == deq_pkg::KIND_POP_BACK);
  assign take_front = (kind_q == deq_pkg::KIND_POP_FRONT);
  assign fp_dec     = (fp_q == '0) ? LastA : (fp_q - 1'b1);
  assign fp_inc     = (fp_q == LastA) ? '0 : (fp_q + 1'b1);

  // Entry memory.
  deq_ram #(
    .Depth (DEPTH),
    .AddrW (AW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (value_q),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // Next-state logic of the sequencer.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      deq_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          state_d = deq_pkg::ST_EXEC;
        end
      end
      deq_pkg::ST_EXEC: begin
        state_d = need_read ? deq_pkg::ST_FILL : deq_pkg::ST_OUT;
      end
      deq_pkg::ST_FILL: begin
        state_d = deq_pkg::ST_OUT;
      end
      deq_pkg::ST_OUT: begin
        if (!out_valid_q || out_ready_i) begin
          state_d = deq_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = deq_pkg::ST_IDLE;
      end
    endcase
  end

  // Datapath controls and next values of the queue state.
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = fp_dec;
    mem_re    = 1'b0;
    mem_raddr = fp_inc;
    need_read = 1'b0;
    out_load  = 1'b0;
    fp_d      = fp_q;
    count_d   = count_q;
    front_d   = front_q;
    back_d    = back_q;
    status_d  = status_q;
    popped_d  = popped_q;

    unique case (state_q)
      deq_pkg::ST_EXEC: begin
        status_d = deq_pkg::STATUS_OK;
        popped_d = '0;
        if (is_push) begin
          if (count_q == DepthC) begin
            status_d = deq_pkg::STATUS_FULL;
          end else begin
            // Write the word at the chosen end and update the cache.
            mem_we  = 1'b1;
            count_d = count_q + 1'b1;
            if (kind_q == deq_pkg::KIND_PUSH_FRONT) begin
              mem_waddr = fp_dec;
              fp_d      = fp_dec;
              front_d   = value_q;
              if (count_q == '0) begin
                back_d = value_q;
              end
            end else begin
              mem_waddr = wrap(SW'(fp_q) + SW'(count_q));
              back_d    = value_q;
              if (count_q == '0) begin
                front_d = value_q;
              end
            end
          end
        end else if (is_pop) begin
          if (count_q == '0) begin
            status_d = deq_pkg::STATUS_EMPTY;
          end else begin
            // Hand out the cached word and fetch its successor if any remain.
            count_d   = count_q - 1'b1;
            need_read = (count_q > CntW'(1));
            mem_re    = need_read;
            if (take_front) begin
              popped_d  = front_q;
              fp_d      = fp_inc;
              mem_raddr = fp_inc;
            end else begin
              popped_d  = back_q;
              mem_raddr = wrap(SW'(fp_q) + SW'(count_q) - SW'(2));
            end
          end
        end
      end
      deq_pkg::ST_FILL: begin
        // Read data refills the end that was popped.
        if (take_front) begin
          front_d = mem_rdata;
        end else begin
          back_d = mem_rdata;
        end
      end
      deq_pkg::ST_OUT: begin
        out_load = !out_valid_q || out_ready_i;
      end
      default: begin
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= deq_pkg::ST_IDLE;
      fp_q        <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      fp_q    <= fp_d;
      count_q <= count_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Request capture, cached end words and result fields.
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      kind_q  <= kind_i;
      value_q <= value_i;
    end
    front_q  <= front_d;
    back_q   <= back_d;
    status_q <= status_d;
    popped_q <= popped_d;
  end

  // Output register; end words read as zero on an empty queue.
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_status_q <= status_q;
      out_popped_q <= popped_q;
      out_count_q  <= deq_pkg::CountOutW'(count_q);
      out_empty_q  <= (count_q == '0);
      out_front_q  <= (count_q == '0) ? '0 : front_q;
      out_back_q   <= (count_q == '0) ? '0 : back_q;
    end
  end

  assign in_ready_o     = (state_q == deq_pkg::ST_IDLE);
  assign out_valid_o    = out_valid_q;
  assign status_o       = out_status_q;
  assign popped_value_o = out_popped_q;
  assign count_o        = out_count_q;
  assign is_empty_o     = out_empty_q;
  assign front_value_o  = out_front_q;
  assign back_value_o   = out_back_q;

endmodule
